[hw/rtl/wtpek_pkg.sv]
// Package for the windowed top-priority event keeper.
// Holds field widths, codes and the entry and window types.
// No dependencies.
package wtpek_pkg;

    localparam int KEEP_COUNT_DEF = 32;
    localparam int TIME_W         = 56;
    localparam int PRIO_W         = 32;
    localparam int RANK_W         = 5;
    localparam int KEPT_W         = 6;
    localparam int TOTAL_W        = 32;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 4;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Register select bit of paddr
    localparam logic CFG_WIN_START = 1'b0;
    localparam logic CFG_WIN_STOP  = 1'b1;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_stop;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_stop;
    } window_t;

endpackage

[hw/rtl/windowed_top_priority_event_keeper.sv]
// Top level of the windowed top-priority event keeper.
// Instantiates wtpek_cfg and a chain of wtpek_cell; depends on wtpek_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries add items (func = 0) and
//   read items (func = 1). Output channel (out_valid / out_stall) returns
//   exactly one result item per input item, in order.
//   An add item is counted, tested against the job window, and if inside
//   the window placed into a chain of KEEP_COUNT cells sorted by descending
//   priority; equal priorities keep arrival order, the lowest entry drops
//   off the end when the chain is full.
//   A read item returns the entry at read_rank.
//   Latency: the result is registered at the edge that accepts the item and
//   is offered from the next cycle. Throughput: one item per cycle unless
//   the output stalls; each cell compares its priority against the new one
//   in parallel and shifts by one rank in the same cycle.
//   The window registers sit on the APB port at byte addresses 0 and 8.
//   Reset clears the entry count, the report total, the output valid and
//   the window (start 0, stop all ones). Entries are not cleared.
//   While the receiver stalls, the result holds and in_stall is raised.
module windowed_top_priority_event_keeper
    import wtpek_pkg::*;
#(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [TIME_W-1:0]     start_time,
    input  logic [TIME_W-1:0]     stop_time,
    input  logic [PRIO_W-1:0]     priority_req,
    input  logic [RANK_W-1:0]     read_rank,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic                  out_of_window,
    output logic                  entry_valid,
    output logic [TIME_W-1:0]     entry_start,
    output logic [TIME_W-1:0]     entry_stop,
    output logic [PRIO_W-1:0]     entry_priority,
    output logic [KEPT_W-1:0]     kept_count,
    output logic [TOTAL_W-1:0]    received_count
);

    localparam int CNT_W     = $clog2(KEEP_COUNT + 1);
    localparam int IDX_W     = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CMP_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int RANK_X_W  = (IDX_W > RANK_W) ? IDX_W : RANK_W;
    localparam int KEPT_X_W  = (CNT_W > KEPT_W) ? CNT_W : KEPT_W;
    localparam int KEPT_MAX  = (2 ** KEPT_W) - 1;

    window_t             window;
    entry_t              new_entry;
    entry_t              cell_q [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] ins_w;
    logic                in_fire;
    logic                is_add;
    logic                oow_c;
    logic                do_insert;
    logic                acc_c;
    logic                hit_c;
    logic [RANK_X_W-1:0] rank_x;
    logic [IDX_W-1:0]    rd_idx;
    entry_t              rd_entry;
    logic [KEPT_X_W-1:0] held_x;

    logic [CNT_W-1:0]    held_reg;
    logic [CNT_W-1:0]    held_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                acc_reg;
    logic                oow_reg;
    logic                ev_reg;
    entry_t              ent_reg;
    logic [KEPT_W-1:0]   kept_reg;
    logic [TOTAL_W-1:0]  recv_reg;

    wtpek_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .window  (window)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign is_add   = (func == FUNC_ADD);

    assign new_entry.t_start = start_time;
    assign new_entry.t_stop  = stop_time;
    assign new_entry.prio    = priority_req;

    assign oow_c     = (start_time > window.t_stop) || (stop_time < window.t_start);
    assign do_insert = in_fire && is_add && !oow_c;

    genvar gi;
    generate
        for (gi = 0; gi < KEEP_COUNT; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                wtpek_cell u_cell (
                    .clk        (clk),
                    .insert_en  (do_insert),
                    .occupied   (CNT_W'(gi) < held_reg),
                    .new_entry  (new_entry),
                    .left_entry (new_entry),
                    .left_ins   (1'b0),
                    .ins        (ins_w[gi]),
                    .entry      (cell_q[gi])
                );
            end
            else
            begin : g_body
                wtpek_cell u_cell (
                    .clk        (clk),
                    .insert_en  (do_insert),
                    .occupied   (CNT_W'(gi) < held_reg),
                    .new_entry  (new_entry),
                    .left_entry (cell_q[gi-1]),
                    .left_ins   (ins_w[gi-1]),
                    .ins        (ins_w[gi]),
                    .entry      (cell_q[gi])
                );
            end
        end
    endgenerate

    // Insert position exists iff the last rank would take the new entry
    assign acc_c = ins_w[KEEP_COUNT-1];

    assign rank_x   = RANK_X_W'(read_rank);
    assign rd_idx   = rank_x[IDX_W-1:0];
    assign rd_entry = cell_q[rd_idx];
    assign hit_c    = CMP_W'(read_rank) < CMP_W'(held_reg);

    always_comb
    begin
        held_next  = held_reg;
        total_next = total_reg;
        if (in_fire && is_add)
        begin
            if (total_reg != TOTAL_MAX)
            begin
                total_next = total_reg + TOTAL_W'(1);
            end
            if (!oow_c && acc_c && (held_reg != CNT_W'(KEEP_COUNT)))
            begin
                held_next = held_reg + CNT_W'(1);
            end
        end
    end

    assign held_x = KEPT_X_W'(held_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            acc_reg  <= is_add && !oow_c && acc_c;
            oow_reg  <= is_add && oow_c;
            ev_reg   <= !is_add && hit_c;
            ent_reg  <= (!is_add && hit_c) ? rd_entry : '0;
            kept_reg <= (held_x > KEPT_X_W'(KEPT_MAX)) ? KEPT_W'(KEPT_MAX)
                                                       : held_x[KEPT_W-1:0];
            recv_reg <= total_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_reg;
    assign out_of_window  = oow_reg;
    assign entry_valid    = ev_reg;
    assign entry_start    = ent_reg.t_start;
    assign entry_stop     = ent_reg.t_stop;
    assign entry_priority = ent_reg.prio;
    assign kept_count     = kept_reg;
    assign received_count = recv_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(KEEP_COUNT))
        else $error("entry count above capacity");

    a_held_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> held_reg >= $past(held_reg))
        else $error("entry count decreased");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(acc_reg && oow_reg) && !(ev_reg && (acc_reg || oow_reg)))
        else $error("conflicting result flags");

    a_acc_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && acc_reg) |-> (kept_reg != '0))
        else $error("stored item but list empty");

    a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> held_reg == $past(held_reg))
        else $error("entry count changed without an item");

endmodule

[hw/rtl/wtpek_cfg.sv]
// APB register file for the job window of the event keeper.
// Depends on wtpek_pkg.
module wtpek_cfg
    import wtpek_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output window_t               window
);

    window_t win_reg;
    window_t win_next;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        win_next = win_reg;
        if (wr_en)
        begin
            unique case (paddr[3])
                CFG_WIN_START: win_next.t_start = pwdata[TIME_W-1:0];
                CFG_WIN_STOP:  win_next.t_stop  = pwdata[TIME_W-1:0];
                default:       win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.t_start <= '0;
            win_reg.t_stop  <= TIME_MAX;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            CFG_WIN_START: prdata = APB_DATA_W'(win_reg.t_start);
            CFG_WIN_STOP:  prdata = APB_DATA_W'(win_reg.t_stop);
            default:       prdata = '0;
        endcase
    end

    assign window = win_reg;

endmodule

[hw/rtl/wtpek_cell.sv]
// One rank of the sorted entry chain.
// Holds one entry; on insert takes the new entry or shifts in its left neighbor.
// Depends on wtpek_pkg.
module wtpek_cell
    import wtpek_pkg::*;
(
    input  logic   clk,
    input  logic   insert_en,
    input  logic   occupied,
    input  entry_t new_entry,
    input  entry_t left_entry,
    input  logic   left_ins,
    output logic   ins,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // New entry ranks at or before this slot
    assign ins = !occupied || (entry_reg.prio < new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (insert_en && ins)
        begin
            entry_next = left_ins ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
